// File: rtl/fcsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_pkg
// Shared types and constants of the filled circle span generator.
// ----------------------------------------------------------------------------
package fcsg_pkg;

  // Field widths of the request and span transactions.
  localparam int CoordW  = 12;
  localparam int RadiusW = 6;
  localparam int ColorW  = 32;
  localparam int PitchW  = 14;
  localparam int PosW    = 14;
  localparam int LenW    = 7;
  localparam int OffW    = 32;

  // Defaults.
  localparam int            MaxRadiusDefault  = 32;
  localparam int            QueueDepthDefault = 2;
  localparam logic [PitchW-1:0] PitchReset    = 14'd640;

  // Packed stream widths, padded to whole bytes.
  localparam int InDataW  = 64;
  localparam int OutDataW = 120;

  // One circle request as it travels from the front to the back.
  typedef struct packed {
    logic [ColorW-1:0]  color;
    logic [RadiusW-1:0] radius;
    logic [CoordW-1:0]  cy;
    logic [CoordW-1:0]  cx;
  } req_t;

  // One span as produced by the back end.
  typedef struct packed {
    logic              last;
    logic [ColorW-1:0] color;
    logic [OffW-1:0]   offset;
    logic [LenW-1:0]   length;
    logic [PosW-1:0]   col_end;
    logic [PosW-1:0]   col_start;
    logic [PosW-1:0]   row;
  } span_t;

endpackage

// File: rtl/filled_circle_span_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filled_circle_span_generator_core
// Turns circle requests into the horizontal spans of a filled disc.
// ----------------------------------------------------------------------------
//   Channel  Direction  Carries
//   s_*      in         circle request: center, radius, fill color
//   m_*      out        span: row, columns, length, offset, color; tlast ends
//   cfg_*    in         row pitch in pixels
//
// In the walk sequencer a circle of radius r takes a load, one boundary test
// per row plus at most r - 1 inward steps in all, and 2r span emissions
// through the output register. Requests queue up in front while a circle is
// walked. Reset is synchronous; the pitch returns to 640.
// A stalled m_tready holds the walk; zero-radius requests produce nothing.
// ----------------------------------------------------------------------------
module filled_circle_span_generator_core #(
  parameter int MAX_RADIUS  = fcsg_pkg::MaxRadiusDefault,
  parameter int QUEUE_DEPTH = fcsg_pkg::QueueDepthDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fcsg_pkg::PitchW-1:0]    cfg_wdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // center_x, center_y, radius, fill_color, zero pad
  input  logic [fcsg_pkg::InDataW-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // span_row, span_col_start, span_col_end, span_length, start_offset,
  // span_color, zero pad
  output logic [fcsg_pkg::OutDataW-1:0]  m_tdata,
  output logic                           m_tlast
);

  logic [fcsg_pkg::PitchW-1:0] pitch;
  logic                        push_valid;
  logic                        push_ready;
  fcsg_pkg::req_t              push_req;
  logic                        pop_valid;
  logic                        pop;
  fcsg_pkg::req_t              pop_req;
  fcsg_pkg::span_t             span;

  // Row pitch register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch <= fcsg_pkg::PitchReset;
    end else if (cfg_we) begin
      pitch <= cfg_wdata;
    end
  end

  fcsg_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  fcsg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_req    (pop_req)
  );

  fcsg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pitch      (pitch),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_req    (pop_req),
    .span_valid (m_tvalid),
    .span_ready (m_tready),
    .span       (span)
  );

  // Output packing.
  assign m_tdata = {7'd0, span.color, span.offset, span.length,
                    span.col_end, span.col_start, span.row};
  assign m_tlast = span.last;

endmodule

// File: rtl/fcsg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_front
// Accepts circle requests, saturates the radius and drops empty circles.
// ----------------------------------------------------------------------------
module fcsg_front #(
  parameter int MAX_RADIUS = fcsg_pkg::MaxRadiusDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [fcsg_pkg::InDataW-1:0]  s_tdata,
  output logic                          push_valid,
  input  logic                          push_ready,
  output fcsg_pkg::req_t                push_req
);

  logic                            hold_valid;
  fcsg_pkg::req_t                  hold_req;
  logic [fcsg_pkg::RadiusW-1:0]    radius_in;
  logic [fcsg_pkg::RadiusW-1:0]    radius_sat;

  // Radius saturation.
  assign radius_in  = s_tdata[29:24];
  assign radius_sat = (radius_in > fcsg_pkg::RadiusW'(MAX_RADIUS)) ?
                      fcsg_pkg::RadiusW'(MAX_RADIUS) : radius_in;

  // The holding stage frees up whenever the queue takes its content.
  assign s_tready   = !hold_valid || push_ready;
  assign push_valid = hold_valid;
  assign push_req   = hold_req;

  // Control: a zero radius yields no spans, so it never enters the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      hold_valid <= (radius_sat != '0);
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_req.cx     <= s_tdata[11:0];
      hold_req.cy     <= s_tdata[23:12];
      hold_req.radius <= radius_sat;
      hold_req.color  <= s_tdata[61:30];
    end
  end

endmodule

// File: rtl/fcsg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_queue
// Small request queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module fcsg_queue #(
  parameter int DEPTH = fcsg_pkg::QueueDepthDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  fcsg_pkg::req_t push_req,
  output logic           pop_valid,
  input  logic           pop,
  output fcsg_pkg::req_t pop_req
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  fcsg_pkg::req_t  entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_req    = entries[rd_ptr];

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_req;
    end
  end

endmodule

// File: rtl/fcsg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_back
// Walks the quadrant boundary of one circle and emits its spans.
// ----------------------------------------------------------------------------
module fcsg_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [fcsg_pkg::PitchW-1:0]   pitch,
  input  logic                          pop_valid,
  output logic                          pop,
  input  fcsg_pkg::req_t                pop_req,
  output logic                          span_valid,
  input  logic                          span_ready,
  output fcsg_pkg::span_t               span
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                          state;
  logic [fcsg_pkg::RadiusW-1:0]    r;
  logic [fcsg_pkg::RadiusW-1:0]    x;
  logic [fcsg_pkg::RadiusW-1:0]    y;
  logic [fcsg_pkg::CoordW-1:0]     cx;
  logic [fcsg_pkg::CoordW-1:0]     cy;
  logic [fcsg_pkg::ColorW-1:0]     color;
  logic                            phase;

  logic [fcsg_pkg::RadiusW-1:0]    dx;
  logic [fcsg_pkg::RadiusW-1:0]    dy;
  logic [11:0]                     corner_sq;
  logic [11:0]                     rr;
  logic                            walk_more;
  logic                            slot_free;
  logic                            emit;
  logic [fcsg_pkg::PosW-1:0]       row;
  logic [fcsg_pkg::PosW-1:0]       c0;
  logic [fcsg_pkg::PosW-1:0]       c1;
  logic signed [fcsg_pkg::PosW-1:0] row_s;
  logic signed [fcsg_pkg::PitchW:0] pitch_s;
  logic signed [fcsg_pkg::PosW+fcsg_pkg::PitchW:0] prod;
  logic [fcsg_pkg::OffW-1:0]       offset;

  // Boundary test: step x inward while the corner lies outside the circle.
  assign dx        = r - x;
  assign dy        = r - y;
  assign corner_sq = 12'({6'd0, dx} * {6'd0, dx}) + 12'({6'd0, dy} * {6'd0, dy});
  assign rr        = 12'({6'd0, r} * {6'd0, r});
  assign walk_more = (x < r) && (corner_sq > rr);

  // Span geometry, all in 14-bit two's complement.
  assign row = phase ? ({2'b00, cy} + {8'd0, r} - {8'd0, y} - 14'd1)
                     : ({2'b00, cy} - {8'd0, r} + {8'd0, y});
  assign c0  = {2'b00, cx} - {8'd0, r} + {8'd0, x};
  assign c1  = {2'b00, cx} + {8'd0, r} - {8'd0, x};

  // Linear offset: one signed multiply followed by the column add.
  assign row_s   = signed'(row);
  assign pitch_s = signed'({1'b0, pitch});
  assign prod    = row_s * pitch_s;
  assign offset  = {{(fcsg_pkg::OffW - fcsg_pkg::PosW - fcsg_pkg::PitchW - 1){prod[28]}}, prod}
                 + {{(fcsg_pkg::OffW - fcsg_pkg::PosW){c0[13]}}, c0};

  assign slot_free = !span_valid || span_ready;
  assign emit      = (state == ST_EMIT) && slot_free;
  assign pop       = (state == ST_IDLE) && pop_valid;

  // Walk sequencer. Once the walk stops, x is always below r, so every row
  // gives two non-empty spans and the mirrored span of the bottom row is last.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            state <= ST_WALK;
            phase <= 1'b0;
          end
        end
        ST_WALK: begin
          if (!walk_more) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (!phase) begin
              phase <= 1'b1;
            end else begin
              phase <= 1'b0;
              state <= (y == 6'd1) ? ST_IDLE : ST_WALK;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Walk position and latched request.
  always_ff @(posedge clk) begin
    if (pop) begin
      r     <= pop_req.radius;
      cx    <= pop_req.cx;
      cy    <= pop_req.cy;
      color <= pop_req.color;
      x     <= '0;
      y     <= pop_req.radius;
    end else if ((state == ST_WALK) && walk_more) begin
      x <= x + 1'b1;
    end else if (emit && phase) begin
      y <= y - 1'b1;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else if (emit) begin
      span_valid <= 1'b1;
    end else if (span_ready) begin
      span_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      span.row       <= row;
      span.col_start <= c0;
      span.col_end   <= c1;
      span.length    <= {dx, 1'b0};
      span.offset    <= offset;
      span.color     <= color;
      span.last      <= phase && (y == 6'd1);
    end
  end

endmodule

// File: rtl/fcsg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_checker
// Port-level checks of the span stream, bound to the top level.
// ----------------------------------------------------------------------------
module fcsg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [fcsg_pkg::OutDataW-1:0] m_tdata,
  input logic                          m_tlast
);

  logic [13:0] width_cols;

  assign width_cols = m_tdata[41:28] - m_tdata[27:14];

  // No span is offered right after reset.
  a_reset_idle : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("span valid right after reset");

  // A stalled span transaction holds its data and last flag.
  a_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled span changed");

  // Span length is even and nonzero.
  a_length : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[48:42] != 7'd0) && !m_tdata[42])
    else $error("bad span length");

  // End minus start equals the length.
  a_extent : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (width_cols == {7'd0, m_tdata[48:42]}))
    else $error("span columns disagree with length");

endmodule

bind filled_circle_span_generator_core fcsg_checker u_fcsg_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
